// ===== rtl/stu_pkg.sv =====
package stu_pkg;

	localparam int CHAR_W            = 8;
	localparam int VALUE_W           = 64;
	localparam int CONSUMED_W        = 12;
	localparam int BASE_W            = 6;
	localparam int DIGIT_W           = 6;
	localparam int PROD_W            = VALUE_W + BASE_W;
	localparam int OUT_DATA_W        = 80;
	localparam int MAX_COUNT_DEFAULT = 4095;
	localparam int QUEUE_DEPTH       = 4;
	localparam int QPTR_W            = $clog2(QUEUE_DEPTH);

	localparam logic [BASE_W-1:0]  BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0]  BASE_AUTO  = 6'd0;
	localparam logic [BASE_W-1:0]  BASE_MIN   = 6'd2;
	localparam logic [BASE_W-1:0]  BASE_MAX   = 6'd36;
	localparam logic [BASE_W-1:0]  BASE_OCT   = 6'd8;
	localparam logic [BASE_W-1:0]  BASE_DEC   = 6'd10;
	localparam logic [BASE_W-1:0]  BASE_HEX   = 6'd16;
	localparam logic [DIGIT_W-1:0] NO_DIGIT   = 6'd63;

	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7a;
	localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5a;
	localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
	localparam logic [CHAR_W-1:0] DIGIT_ALPHA_OFS = 8'd10;

	// One classified character as it travels from front to back.
	typedef struct packed {
		logic               eot;
		logic               is_space;
		logic               is_plus;
		logic               is_minus;
		logic               is_zero;
		logic               is_x;
		logic [DIGIT_W-1:0] digit;
	} stu_entry_t;

	typedef struct packed {
		logic       valid;
		stu_entry_t entry;
	} stu_slot_t;

endpackage

// ===== rtl/stu_front.sv =====
module stu_front import stu_pkg::*; (
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [CHAR_W-1:0] s_axis_tdata,   // [7:0] char_byte
	input  logic              s_axis_tlast,   // end_of_text
	input  logic              q_full,
	output stu_slot_t         push
);

	logic [CHAR_W-1:0] dig;

	always_comb begin
		if (s_axis_tdata >= CH_0 && s_axis_tdata <= CH_9) begin
			dig = s_axis_tdata - CH_0;
		end else if (s_axis_tdata >= CH_LC_A && s_axis_tdata <= CH_LC_Z) begin
			dig = s_axis_tdata - CH_LC_A + DIGIT_ALPHA_OFS;
		end else if (s_axis_tdata >= CH_UC_A && s_axis_tdata <= CH_UC_Z) begin
			dig = s_axis_tdata - CH_UC_A + DIGIT_ALPHA_OFS;
		end else begin
			dig = CHAR_W'(NO_DIGIT);
		end
	end

	assign s_axis_tready = !q_full;

	always_comb begin
		push.valid          = s_axis_tvalid && !q_full;
		push.entry.eot      = s_axis_tlast;
		push.entry.is_space = (s_axis_tdata == CH_SPACE) ||
		                      (s_axis_tdata >= CH_TAB && s_axis_tdata <= CH_CR);
		push.entry.is_plus  = (s_axis_tdata == CH_PLUS);
		push.entry.is_minus = (s_axis_tdata == CH_MINUS);
		push.entry.is_zero  = (s_axis_tdata == CH_0);
		push.entry.is_x     = (s_axis_tdata == CH_LC_X) || (s_axis_tdata == CH_UC_X);
		push.entry.digit    = dig[DIGIT_W-1:0];
	end

endmodule

// ===== rtl/stu_queue.sv =====
module stu_queue import stu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  stu_slot_t push,
	output logic      full,
	input  logic      pop,
	output stu_slot_t head
);

	stu_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign do_push = push.valid && !full;
	assign do_pop  = pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_full_blocks_push: assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_pop |=> $stable(wr_ptr_q))
		else $error("queue written while full");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		QPTR_W'(cnt_q) == QPTR_W'(wr_ptr_q - rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

// ===== rtl/stu_back.sv =====
module stu_back import stu_pkg::*; #(
	parameter int MAX_COUNT = MAX_COUNT_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [BASE_W-1:0]     base_setting,
	input  stu_slot_t             head,
	output logic                  pop,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tuser
);

	localparam int CNT_W = $clog2(MAX_COUNT + 1);

	typedef enum logic [5:0] {
		PH_SPACE  = 6'b000001,
		PH_SIGN   = 6'b000010,
		PH_ZERO   = 6'b000100,
		PH_XSEEN  = 6'b001000,
		PH_DIGITS = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	phase_t             phase_q, phase_d, ph, fin_ph;
	logic [VALUE_W-1:0] acc_q, acc_d;
	logic               ovf_q, ovf_d;
	logic               minus_q, minus_d;
	logic [BASE_W-1:0]  wbase_q, wbase_d, wb;
	logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_inc;
	logic [CNT_W-1:0]   fb_q, fb_d;
	logic               handled;
	logic               produce;
	logic               go;
	logic [PROD_W-1:0]  prod;
	stu_entry_t         e;

	logic                  out_valid_q;
	logic [VALUE_W-1:0]    out_value_q, res_value;
	logic [CONSUMED_W-1:0] out_cnt_q, res_cnt;
	logic                  out_oor_q, res_oor;

	function automatic logic digit_ok(logic [DIGIT_W-1:0] d, logic [BASE_W-1:0] b);
		return (b >= BASE_MIN) && (b <= BASE_MAX) && (BASE_W'(d) < b);
	endfunction

	assign e       = head.entry;
	assign go      = head.valid && (!out_valid_q || m_axis_tready);
	assign pop     = go;
	assign cnt_inc = (cnt_q < CNT_W'(MAX_COUNT)) ? cnt_q + 1'b1 : cnt_q;
	assign prod    = PROD_W'(acc_q) * PROD_W'(wb) + PROD_W'(e.digit);

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		ovf_d   = ovf_q;
		minus_d = minus_q;
		wbase_d = wbase_q;
		cnt_d   = cnt_q;
		fb_d    = fb_q;
		ph      = phase_q;
		fin_ph  = phase_q;
		wb      = wbase_q;
		handled = 1'b0;
		produce = 1'b0;
		if (go && e.eot) begin
			// terminator: report unless already reported, then rearm
			produce = (phase_q != PH_DONE);
			phase_d = PH_SPACE;
			acc_d   = '0;
			ovf_d   = 1'b0;
			minus_d = 1'b0;
			wbase_d = '0;
			cnt_d   = '0;
			fb_d    = '0;
		end else if (go) begin
			if (ph == PH_SPACE) begin
				if (e.is_space) begin
					cnt_d   = cnt_inc;
					handled = 1'b1;
				end else if (e.is_plus || e.is_minus) begin
					minus_d = e.is_minus;
					cnt_d   = cnt_inc;
					phase_d = PH_SIGN;
					handled = 1'b1;
				end else begin
					ph = PH_SIGN;
				end
			end
			if (!handled && ph == PH_SIGN) begin
				if (e.is_zero && (base_setting == BASE_AUTO || base_setting == BASE_HEX)) begin
					cnt_d   = cnt_inc;
					fb_d    = cnt_inc;
					wbase_d = base_setting;
					acc_d   = '0;
					phase_d = PH_ZERO;
				end else begin
					wb      = (base_setting == BASE_AUTO) ? BASE_DEC : base_setting;
					wbase_d = wb;
					if (digit_ok(e.digit, wb)) begin
						acc_d   = VALUE_W'(e.digit);
						cnt_d   = cnt_inc;
						phase_d = PH_DIGITS;
					end else begin
						produce = 1'b1;
						fin_ph  = PH_SIGN;
						phase_d = PH_DONE;
					end
				end
				handled = 1'b1;
			end
			if (!handled && ph == PH_ZERO) begin
				if (e.is_x) begin
					cnt_d   = cnt_inc;
					wbase_d = BASE_HEX;
					phase_d = PH_XSEEN;
					handled = 1'b1;
				end else begin
					wb      = (wbase_q == BASE_AUTO) ? BASE_OCT : BASE_HEX;
					wbase_d = wb;
					ph      = PH_DIGITS;
				end
			end
			if (!handled && ph == PH_XSEEN) begin
				if (digit_ok(e.digit, BASE_HEX)) begin
					acc_d   = VALUE_W'(e.digit);
					cnt_d   = cnt_inc;
					phase_d = PH_DIGITS;
				end else begin
					produce = 1'b1;
					fin_ph  = PH_XSEEN;
					phase_d = PH_DONE;
				end
				handled = 1'b1;
			end
			if (!handled && ph == PH_DIGITS) begin
				if (digit_ok(e.digit, wb)) begin
					// any bit above the low 64 bits of acc*base+digit is an overflow
					ovf_d   = ovf_q || (prod[PROD_W-1:VALUE_W] != '0);
					acc_d   = prod[VALUE_W-1:0];
					cnt_d   = cnt_inc;
					phase_d = PH_DIGITS;
				end else begin
					produce = 1'b1;
					fin_ph  = PH_DIGITS;
					phase_d = PH_DONE;
				end
			end
		end
	end

	always_comb begin
		res_value = '0;
		res_cnt   = '0;
		res_oor   = 1'b0;
		unique case (fin_ph) inside
			PH_XSEEN: begin
				// 0x without a hex digit: count stops after the 0
				res_cnt = CONSUMED_W'(fb_q);
			end
			PH_ZERO, PH_DIGITS: begin
				res_cnt = CONSUMED_W'(cnt_q);
				if (ovf_q) begin
					res_value = '1;
					res_oor   = 1'b1;
				end else begin
					res_value = minus_q ? (VALUE_W'(0) - acc_q) : acc_q;
				end
			end
			default: begin
				res_value = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			minus_q <= 1'b0;
			wbase_q <= '0;
			cnt_q   <= '0;
			fb_q    <= '0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			ovf_q   <= ovf_d;
			minus_q <= minus_d;
			wbase_q <= wbase_d;
			cnt_q   <= cnt_d;
			fb_q    <= fb_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (produce) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			out_value_q <= res_value;
			out_cnt_q   <= res_cnt;
			out_oor_q   <= res_oor;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'({out_cnt_q, out_value_q});
	assign m_axis_tuser  = out_oor_q;

	a_oor_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_oor_q |-> out_value_q == '1)
		else $error("out-of-range result not saturated");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |-> !go)
		else $error("item consumed while result stalled");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		go && phase_q == PH_DONE && !e.eot |-> !produce)
		else $error("second result for one text");

	a_eot_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		go && e.eot |=> phase_q == PH_SPACE && cnt_q == '0)
		else $error("terminator did not rearm scan");

	a_digit_base: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DIGITS |-> wbase_q >= BASE_MIN && wbase_q <= BASE_MAX)
		else $error("digit phase with invalid base");

endmodule

// ===== rtl/string_to_unsigned_integer.sv =====
// A terminating or stopping character is classified by the front and written into the
//   queue, then the back's scan step registers its result onto m_axis.
// Throughput: one character per cycle, set by the back's combinational multiply-add
//   of the accumulator by the base; the back pauses only while a result waits.
// Reset: arst_n asynchronously clears the scan, the queue and the output stage and
//   loads base_setting with 10; there is no clearing pass.
module string_to_unsigned_integer import stu_pkg::*; #(
	parameter int MAX_COUNT = MAX_COUNT_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [BASE_W-1:0]     cfg_data,       // [5:0] base_setting
	// character stream in
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [CHAR_W-1:0]     s_axis_tdata,   // [7:0] char_byte
	input  logic                  s_axis_tlast,   // end_of_text
	// result stream out
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [63:0] value, [75:64] consumed_count,
	                                              // [79:76] zero
	output logic                  m_axis_tuser    // out_of_range
);

	logic [BASE_W-1:0] base_q;
	stu_slot_t         push;
	stu_slot_t         head;
	logic              q_full;
	logic              pop;

	// The base register takes a write in any cycle; writes should land only while idle, which the user must ensure.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	// Front: accept a character and classify it (digit value, space, sign, zero, x).
	stu_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.push          (push)
	);

	// Short queue: lets the front keep taking items while the back holds a result.
	stu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	// Back: scan phases, base resolution, accumulate with overflow, result register.
	stu_back #(
		.MAX_COUNT (MAX_COUNT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.base_setting  (base_q),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== verif/string_to_unsigned_integer_tb.sv =====
`timescale 1ns / 100ps

module string_to_unsigned_integer_tb;
	import stu_pkg::*;

	localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
	localparam logic [BASE_W-1:0]  BASE_BELOW = 6'd1;   // one under the lowest real base
	localparam logic [BASE_W-1:0]  BASE_ABOVE = 6'd37;  // one over the highest real base
	localparam logic [BASE_W-1:0]  BASE_TOP   = 6'd63;  // largest register value
	localparam int STALL_LIMIT   = 2000;  // cycles without any handshake before giving up
	localparam int DRAIN_CYCLES  = 8;     // covers the two-stage path plus the front queue
	localparam int LONG_HOLD     = 120;   // receiver back-pressure stretch
	localparam int RANDOM_TARGET = 1450;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0]    value;
		logic [CONSUMED_W-1:0] count;
		logic                  oor;
	} conversion_t;

	typedef enum logic [2:0] {
		ST_BLANKS,
		ST_SIGNED,
		ST_LEAD_ZERO,
		ST_HEX_MARK,
		ST_DIGITS,
		ST_STOPPED
	} scan_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [BASE_W-1:0]     cfg_data = BASE_RESET;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [CHAR_W-1:0]     s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	// stimulus and scoreboard
	char_item_t  pending_chars[$];
	conversion_t expected_conversions[$];
	int          stim_count = 0;
	int          mismatches = 0;
	int          tx_gap = 0;
	int          rx_gap = 0;
	int          hold_left = 0;
	int          hold_requests = 0;
	int          holds_served = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;

	// predictor state, mirrors the block's scan
	logic [BASE_W-1:0]  base_reg = BASE_RESET;
	scan_t              scan_state;
	logic [VALUE_W-1:0] accum;
	bit                 ovf;
	bit                 neg;
	logic [BASE_W-1:0]  wbase;
	int unsigned        seen_chars;
	int unsigned        zero_mark;

	string_to_unsigned_integer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Conversion predictor
	// ---------------------------------------------------------------

	function automatic logic [DIGIT_W-1:0] char_digit(input logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] v;
		if (ch >= CH_0 && ch <= CH_9)
			v = ch - CH_0;
		else if (ch >= CH_LC_A && ch <= CH_LC_Z)
			v = ch - CH_LC_A + DIGIT_ALPHA_OFS;
		else if (ch >= CH_UC_A && ch <= CH_UC_Z)
			v = ch - CH_UC_A + DIGIT_ALPHA_OFS;
		else
			v = CHAR_W'(NO_DIGIT);
		return v[DIGIT_W-1:0];
	endfunction

	function automatic bit digit_fits(input logic [DIGIT_W-1:0] d, input logic [BASE_W-1:0] b);
		return b >= BASE_MIN && b <= BASE_MAX && d < b;
	endfunction

	function automatic void count_char();
		if (seen_chars < MAX_COUNT_DEFAULT)
			seen_chars++;
	endfunction

	function automatic void restart_scan();
		scan_state = ST_BLANKS;
		accum      = '0;
		ovf        = 1'b0;
		neg        = 1'b0;
		wbase      = '0;
		seen_chars = 0;
		zero_mark  = 0;
	endfunction

	// Multiply-add with the usual cutoff test for 64-bit overflow.
	function automatic void take_digit(input logic [DIGIT_W-1:0] dg);
		logic [VALUE_W-1:0] cutoff;
		logic [VALUE_W-1:0] cutlim;
		cutoff = VALUE_MAX / wbase;
		cutlim = VALUE_MAX % wbase;
		if (accum > cutoff || (accum == cutoff && dg > cutlim))
			ovf = 1'b1;
		accum = accum * wbase + dg;
		count_char();
	endfunction

	function automatic conversion_t conclude();
		conversion_t r;
		r = '0;
		if (scan_state == ST_HEX_MARK) begin
			// "0x" with no hex digit: only the zero counts
			r.count = zero_mark[CONSUMED_W-1:0];
		end else if (scan_state == ST_LEAD_ZERO || scan_state == ST_DIGITS) begin
			r.count = seen_chars[CONSUMED_W-1:0];
			if (ovf) begin
				r.value = VALUE_MAX;
				r.oor   = 1'b1;
			end else begin
				r.value = neg ? 64'd0 - accum : accum;
			end
		end
		scan_state = ST_STOPPED;
		return r;
	endfunction

	// Advance the scan by one accepted item; returns 1 when it yields a result.
	function automatic bit convert_char(input logic [CHAR_W-1:0] ch, input logic eot,
			output conversion_t r);
		logic [DIGIT_W-1:0] dg;
		bit                 hit;
		dg = char_digit(ch);
		r  = '0;
		if (eot) begin
			hit = (scan_state != ST_STOPPED);
			if (hit)
				r = conclude();
			restart_scan();
			return hit;
		end
		if (scan_state == ST_BLANKS) begin
			if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
				count_char();
				return 1'b0;
			end
			if (ch == CH_MINUS || ch == CH_PLUS) begin
				neg = (ch == CH_MINUS);
				count_char();
				scan_state = ST_SIGNED;
				return 1'b0;
			end
			scan_state = ST_SIGNED;
		end
		if (scan_state == ST_SIGNED) begin
			// base is latched here, on the first character past blanks and sign
			if (ch == CH_0 && (base_reg == BASE_AUTO || base_reg == BASE_HEX)) begin
				count_char();
				zero_mark  = seen_chars;
				wbase      = base_reg;
				accum      = '0;
				scan_state = ST_LEAD_ZERO;
				return 1'b0;
			end
			wbase = (base_reg == BASE_AUTO) ? BASE_DEC : base_reg;
			if (digit_fits(dg, wbase)) begin
				accum = VALUE_W'(dg);
				count_char();
				scan_state = ST_DIGITS;
				return 1'b0;
			end
			r = conclude();
			return 1'b1;
		end
		if (scan_state == ST_LEAD_ZERO) begin
			if (ch == CH_LC_X || ch == CH_UC_X) begin
				count_char();
				wbase      = BASE_HEX;
				scan_state = ST_HEX_MARK;
				return 1'b0;
			end
			wbase      = (wbase == BASE_AUTO) ? BASE_OCT : BASE_HEX;
			scan_state = ST_DIGITS;
		end
		if (scan_state == ST_HEX_MARK) begin
			if (digit_fits(dg, BASE_HEX)) begin
				accum = VALUE_W'(dg);
				count_char();
				scan_state = ST_DIGITS;
				return 1'b0;
			end
			r = conclude();
			return 1'b1;
		end
		if (scan_state == ST_DIGITS) begin
			if (digit_fits(dg, wbase)) begin
				take_digit(dg);
				return 1'b0;
			end
			r = conclude();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------
	// Text generation
	// ---------------------------------------------------------------

	task automatic push_item(input logic [CHAR_W-1:0] ch, input logic last);
		char_item_t it;
		it.ch   = ch;
		it.last = last;
		pending_chars.push_back(it);
		stim_count++;
	endtask

	task automatic push_char(input logic [CHAR_W-1:0] ch);
		push_item(ch, 1'b0);
	endtask

	// end marker: its character is never consumed, so any byte will do
	task automatic push_end();
		push_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endtask

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		if (d < DIGIT_ALPHA_OFS)
			return CH_0 + d;
		if ($urandom_range(0, 1))
			return CH_LC_A + d - DIGIT_ALPHA_OFS;
		return CH_UC_A + d - DIGIT_ALPHA_OFS;
	endfunction

	function automatic logic [CHAR_W-1:0] pick_blank();
		if ($urandom_range(0, 1))
			return CH_SPACE;
		return CH_TAB + CHAR_W'($urandom_range(0, 4));
	endfunction

	task automatic push_number(input logic [VALUE_W-1:0] v, input logic [BASE_W-1:0] b);
		logic [DIGIT_W-1:0] digs[$];
		logic [VALUE_W-1:0] x;
		x = v;
		do begin
			digs.push_front(DIGIT_W'(x % b));
			x = x / b;
		end while (x != 0);
		foreach (digs[i])
			push_char(digit_char(digs[i]));
	endtask

	// Mostly well-formed numbers in the current base; some noise and broken prefixes.
	task automatic random_text();
		logic [BASE_W-1:0] b;
		int                shape;
		int                n;
		shape = $urandom_range(0, 19);
		if (shape == 0) begin
			n = $urandom_range(0, 6);
			repeat (n) push_char(CHAR_W'($urandom_range(0, 255)));
			push_end();
			return;
		end
		repeat ($urandom_range(0, 2)) push_char(pick_blank());
		case ($urandom_range(0, 5))
			0: push_char(CH_MINUS);
			1: push_char(CH_PLUS);
			default: ;
		endcase
		// second sign or a blank after the sign kills the conversion
		if (shape == 1)
			push_char($urandom_range(0, 1) ? CH_MINUS : pick_blank());
		b = base_reg;
		if (b == BASE_AUTO) begin
			case ($urandom_range(0, 2))
				0: begin
					push_char(CH_0);
					push_char($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
					b = BASE_HEX;
				end
				1: begin
					push_char(CH_0);
					b = BASE_OCT;
				end
				default: b = BASE_DEC;
			endcase
		end else if (b == BASE_HEX && $urandom_range(0, 1)) begin
			push_char(CH_0);
			push_char($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
		end else if (b < BASE_MIN || b > BASE_MAX) begin
			b = BASE_DEC;
		end
		if (shape != 2) begin
			case ($urandom_range(0, 5))
				0, 1: push_number(VALUE_W'($urandom_range(0, 1000)), b);
				2: push_number({$urandom, $urandom}, b);
				3: push_number(VALUE_MAX, b);
				4: begin
					// land right on the cutoff, then one digit either side of the limit
					push_number(VALUE_MAX / b, b);
					push_char(digit_char(DIGIT_W'($urandom_range(0, b - 1))));
				end
				default: repeat ($urandom_range(1, 70))
					push_char(digit_char(DIGIT_W'($urandom_range(0, b - 1))));
			endcase
		end
		if ($urandom_range(0, 1)) begin
			push_end();
		end else begin
			push_char(CHAR_W'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 4)) push_item(CHAR_W'($urandom_range(0, 255)), 1'b0);
			push_end();
		end
	endtask

	// ---------------------------------------------------------------
	// Phase control
	// ---------------------------------------------------------------

	task automatic write_base(input logic [BASE_W-1:0] b);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= b;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_reg = b;
	endtask

	// Hold until every item is in and every result is out, then let the pipe empty.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_chars.size() != 0 || s_axis_tvalid || expected_conversions.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [BASE_W-1:0] b, input int target, input bit idle);
		int start;
		write_base(b);
		@(negedge clk);
		tx_idle_on = idle;
		rx_idle_on = idle;
		start = stim_count;
		while (stim_count - start < target)
			random_text();
		wait_drained();
	endtask

	function automatic logic [BASE_W-1:0] base_for_phase(input int p);
		case (p)
			0: return BASE_AUTO;
			1: return BASE_HEX;
			2: return BASE_MIN;
			3: return BASE_MAX;
			4: return BASE_OCT;
			5: return BASE_DEC;
			6: return BASE_BELOW;
			7: return BASE_ABOVE;
			8: return BASE_TOP;
			default: case ($urandom_range(0, 3))
				0: return BASE_AUTO;
				1: return BASE_HEX;
				2: return BASE_DEC;
				default: return BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
			endcase
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
			input logic [VALUE_W-1:0] want);
		$display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	// ---------------------------------------------------------------
	// Character driver: feed pending items, predict on every accepted one
	// ---------------------------------------------------------------
	always @(posedge clk) begin : char_driver
		conversion_t res;
		char_item_t  nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			tx_gap        <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (convert_char(s_axis_tdata, s_axis_tlast, res))
					expected_conversions.push_back(res);
			end
			// hold a stalled item as it is; otherwise idle or advance
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap != 0) begin
					s_axis_tvalid <= 1'b0;
					tx_gap        <= tx_gap - 1;
				end else if (tx_idle_on && $urandom_range(0, 9) == 0) begin
					s_axis_tvalid <= 1'b0;
					tx_gap        <= $urandom_range(0, 11);
				end else if (pending_chars.size() != 0) begin
					nxt = pending_chars.pop_front();
					s_axis_tdata  <= nxt.ch;
					s_axis_tlast  <= nxt.last;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Result receiver: random stalls plus the long hold on request
	// ---------------------------------------------------------------
	always @(posedge clk) begin : result_ready
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_gap        <= 0;
			hold_left     <= 0;
		end else if (holds_served != hold_requests) begin
			holds_served  <= hold_requests;
			hold_left     <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_gap != 0) begin
			rx_gap        <= rx_gap - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
			rx_gap        <= $urandom_range(0, 11);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Result monitor: compare each accepted result with the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin : result_check
		conversion_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_conversions.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata[VALUE_W-1:0], '0);
			end else begin
				want = expected_conversions.pop_front();
				if (m_axis_tdata[VALUE_W-1:0] !== want.value)
					report_mismatch("value", m_axis_tdata[VALUE_W-1:0], want.value);
				if (m_axis_tdata[VALUE_W +: CONSUMED_W] !== want.count)
					report_mismatch("consumed_count",
						VALUE_W'(m_axis_tdata[VALUE_W +: CONSUMED_W]),
						VALUE_W'(want.count));
				if (m_axis_tuser !== want.oor)
					report_mismatch("out_of_range", VALUE_W'(m_axis_tuser),
						VALUE_W'(want.oor));
			end
		end
	end

	// Drop the run if nothing moves on any channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("string_to_unsigned_integer regression: fail");
		$finish;
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin : main_seq
		int p;
		int random_start;
		restart_scan();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// automatic base: signed hex, lone "0x", octal, stop after a zero,
		// empty text, second sign, blank after sign
		write_base(BASE_AUTO);
		@(negedge clk);
		push_text(" \t-0x1F");
		push_end();
		push_text("0x");
		push_end();
		push_text("017");
		push_end();
		push_text("0g9");
		push_end();
		push_end();
		push_text("+-5");
		push_end();
		push_text("- 5");
		push_end();
		wait_drained();

		// fixed hex: prefix taken, and "0x" followed by a non-hex char and junk
		write_base(BASE_HEX);
		@(negedge clk);
		push_text("0XfF");
		push_end();
		push_text("0xz1");
		push_end();
		wait_drained();

		// base 36 overflow after a minus sign
		write_base(BASE_MAX);
		@(negedge clk);
		push_text("-ZZZZZZZZZZZZZZ");
		push_end();
		wait_drained();

		// base 2: exactly all ones, stopped by a digit outside the base
		write_base(BASE_MIN);
		@(negedge clk);
		repeat (64) push_char(CH_0 + 8'd1);
		push_char(CH_0 + 8'd2);
		push_end();
		wait_drained();

		// bases that accept no digit at all
		write_base(BASE_BELOW);
		@(negedge clk);
		push_text("01");
		push_end();
		wait_drained();
		write_base(BASE_TOP);
		@(negedge clk);
		push_text("z");
		push_end();
		wait_drained();

		// change the base between the sign and the first digit
		write_base(BASE_DEC);
		@(negedge clk);
		push_text("  +");
		wait_drained();
		write_base(BASE_HEX);
		@(negedge clk);
		push_text("1f");
		push_end();
		wait_drained();

		// long text of blanks and leading zeros
		write_base(BASE_DEC);
		@(negedge clk);
		repeat (100) push_item(CH_SPACE, 1'b0);
		repeat (100) push_item(CH_0, 1'b0);
		push_text("5");
		push_end();
		wait_drained();

		// stall the result side for a long stretch while short texts keep coming,
		// so the block fills and drops its input ready
		@(negedge clk);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (40) begin
			push_char(digit_char(DIGIT_W'($urandom_range(0, 9))));
			push_end();
		end
		hold_requests++;
		wait_drained();

		// random phases: sweep the base extremes first, then random bases;
		// every third phase runs without idling
		random_start = stim_count;
		p = 0;
		while (stim_count - random_start < RANDOM_TARGET - 200) begin
			run_phase(base_for_phase(p),
				(p >= 6 && p <= 8) ? 30 : 150, (p % 3) != 2);
			p++;
		end

		// closing stretch with no idling on either side
		run_phase(base_for_phase(p), 200, 1'b0);

		if (mismatches == 0)
			$display("string_to_unsigned_integer regression: pass");
		else
			$display("string_to_unsigned_integer regression: fail");
		$finish;
	end

endmodule
